/* rtl/core/olist_pkg.sv */
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and codes for the ordered list engine and its storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package olist_pkg;

   // request kinds
   localparam logic [1:0] KIND_APPEND = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;
   localparam logic [1:0] KIND_DUMP   = 2'd3;

   // response status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_RANGE    = 3'd1;
   localparam logic [2:0] STATUS_NOTFOUND = 3'd2;
   localparam logic [2:0] STATUS_EMPTY    = 3'd3;
   localparam logic [2:0] STATUS_FULL     = 3'd4;

   // wide enough for any cell index or count up to the largest capacity
   localparam int IDX_W = 9;
   typedef logic [IDX_W-1:0] idx_type;

   typedef logic signed [31:0] data_type;

   // cell update modes
   typedef logic [1:0] cell_mode_type;
   localparam cell_mode_type CELL_HOLD   = 2'd0;
   localparam cell_mode_type CELL_INSERT = 2'd1;
   localparam cell_mode_type CELL_ROTATE = 2'd2;
   localparam cell_mode_type CELL_SHIFT  = 2'd3;

   // control broadcast to every cell of the chain
   typedef struct packed {
      cell_mode_type mode;
      idx_type       target;
      data_type      value;
   } cell_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/olist_cell.sv */
// ----------------------------------------------------------------------------
// olist_cell
// One list slot: holds an element and trades it with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_cell #(
   parameter int INDEX = 0
) (
   input  wire                     clock,
   input  olist_pkg::cell_ctl_type ctl,
   input  olist_pkg::data_type     left_data,
   input  olist_pkg::data_type     right_data,
   input  olist_pkg::data_type     head_data,
   output olist_pkg::data_type     data
);

   localparam olist_pkg::idx_type MY_IDX = olist_pkg::idx_type'(INDEX);

   olist_pkg::data_type data_ff;
   olist_pkg::data_type data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctl.mode)
         olist_pkg::CELL_HOLD: begin
            data_in = data_ff;
         end
         olist_pkg::CELL_INSERT: begin
            // slots past the insert point move one place toward the tail
            if (MY_IDX == ctl.target) begin
               data_in = ctl.value;
            end else if (MY_IDX > ctl.target) begin
               data_in = left_data;
            end
         end
         olist_pkg::CELL_ROTATE: begin
            // head wraps around into the tail slot
            if (MY_IDX == ctl.target) begin
               data_in = head_data;
            end else begin
               data_in = right_data;
            end
         end
         olist_pkg::CELL_SHIFT: begin
            data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

/* rtl/core/ordered_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Ordered list of signed 32-bit values held in a chain of shifting cells.
// ----------------------------------------------------------------------------
//  channel   ports                              direction
//  req       req_valid/ready, kind/value/pos    in
//  rsp       rsp_valid/ready, status/elem/last  out
//
//  append and insert need no rotation: every cell shifts or loads in parallel.
//  delete and dump rotate the chain once around, one element per cycle.
//  reset clears the element count; cell contents are left as they were.
//  a stalled response freezes the rotation; a new request is taken only
//  when the engine is idle and the response register is free.
`default_nettype none

module ordered_list_engine_unit #(
   parameter int CAPACITY = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [1:0]         req_kind,
   input  wire  signed [31:0] req_value,
   input  wire  [7:0]         req_position,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_element,
   output logic               rsp_last
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DELETE = 2'd1;
   localparam logic [1:0] S_DUMP   = 2'd2;

   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]    len_ff, len_in;
   logic                found_ff, found_in;
   olist_pkg::data_type key_ff, key_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   olist_pkg::data_type rsp_element_ff, rsp_element_in;
   logic                rsp_last_ff, rsp_last_in;

   olist_pkg::cell_ctl_type ctl;
   olist_pkg::data_type     cell_data [CAPACITY];
   olist_pkg::data_type     head;

   logic             out_can_load;
   logic             accept;
   logic             hit;
   logic             final_step;
   olist_pkg::idx_type count_x;
   olist_pkg::idx_type pos_x;

   assign head         = cell_data[0];
   assign out_can_load = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == S_IDLE) && out_can_load;
   assign accept       = req_valid && req_ready;
   assign count_x      = olist_pkg::idx_type'(count_ff);
   assign pos_x        = olist_pkg::idx_type'(req_position);
   assign hit          = !found_ff && (head == key_ff);
   assign final_step   = (step_ff == count_ff - 1'b1);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      len_in         = len_ff;
      found_in       = found_ff;
      key_in         = key_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      ctl.mode       = olist_pkg::CELL_HOLD;
      ctl.target     = '0;
      ctl.value      = req_value;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = olist_pkg::STATUS_OK;
               rsp_element_in = '0;
               rsp_last_in    = 1'b1;
               unique case (req_kind)
                  olist_pkg::KIND_APPEND: begin
                     if (count_ff == CAP_COUNT) begin
                        rsp_status_in = olist_pkg::STATUS_FULL;
                     end else begin
                        ctl.mode   = olist_pkg::CELL_INSERT;
                        ctl.target = count_x;
                        count_in   = count_ff + 1'b1;
                     end
                  end
                  olist_pkg::KIND_INSERT: begin
                     if (req_position == 8'd0 || pos_x > count_x + 1'b1) begin
                        rsp_status_in = olist_pkg::STATUS_RANGE;
                     end else if (count_ff == CAP_COUNT) begin
                        rsp_status_in = olist_pkg::STATUS_FULL;
                     end else begin
                        ctl.mode   = olist_pkg::CELL_INSERT;
                        ctl.target = pos_x - 1'b1;
                        count_in   = count_ff + 1'b1;
                     end
                  end
                  olist_pkg::KIND_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_status_in = olist_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_DELETE;
                        step_in      = '0;
                        len_in       = count_ff;
                        found_in     = 1'b0;
                        key_in       = req_value;
                     end
                  end
                  olist_pkg::KIND_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = olist_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_DUMP;
                        step_in      = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         S_DELETE: begin
            if (out_can_load) begin
               // first match is dropped instead of wrapping to the tail
               if (hit) begin
                  ctl.mode = olist_pkg::CELL_SHIFT;
                  len_in   = len_ff - 1'b1;
                  found_in = 1'b1;
               end else begin
                  ctl.mode   = olist_pkg::CELL_ROTATE;
                  ctl.target = olist_pkg::idx_type'(len_ff) - 1'b1;
               end
               step_in = step_ff + 1'b1;
               if (final_step) begin
                  count_in       = hit ? len_ff - 1'b1 : len_ff;
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = (found_ff || hit) ? olist_pkg::STATUS_OK
                                                     : olist_pkg::STATUS_NOTFOUND;
                  rsp_element_in = '0;
                  rsp_last_in    = 1'b1;
                  state_in       = S_IDLE;
               end
            end
         end
         S_DUMP: begin
            if (out_can_load) begin
               ctl.mode       = olist_pkg::CELL_ROTATE;
               ctl.target     = count_x - 1'b1;
               step_in        = step_ff + 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = olist_pkg::STATUS_OK;
               rsp_element_in = head;
               rsp_last_in    = final_step;
               if (final_step) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      olist_pkg::data_type left_d;
      olist_pkg::data_type right_d;
      if (g == 0) begin : g_first
         assign left_d = cell_data[g];
      end else begin : g_mid_l
         assign left_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_d = cell_data[g];
      end else begin : g_mid_r
         assign right_d = cell_data[g+1];
      end
      olist_cell #(
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_data  (left_d),
         .right_data (right_d),
         .head_data  (head),
         .data       (cell_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         len_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         len_ff       <= len_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

`default_nettype wire

/* tb/sv/tb_ordered_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_unit
// Self-checking bench for the ordered list engine: a shadow list predicts the
// response of every request, and each response is checked in order.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY     = 16;
   localparam int CYCLE_LIMIT  = 250000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [2:0]          status;
      olist_pkg::data_type element;
      logic                last;
   } list_reply_type;

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic [1:0]        req_kind     = olist_pkg::KIND_APPEND;
   logic signed [31:0] req_value   = '0;
   logic [7:0]        req_position = '0;
   logic              rsp_ready    = 1'b0;
   wire               req_ready;
   wire               rsp_valid;
   wire  [2:0]        rsp_status;
   wire  signed [31:0] rsp_element;
   wire               rsp_last;

   list_reply_type      awaited_replies[$];
   olist_pkg::data_type shadow_list[$];
   bit          idling_on;
   int          stall_left;
   int          mismatch_count;
   int          sent_count;
   int          checked_count;
   int          full_count;
   int          cycle_count;

   ordered_list_engine_unit #(.CAPACITY(CAPACITY)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void expect_reply(logic [2:0] status,
                                        olist_pkg::data_type element, logic last);
      list_reply_type r;
      r.status  = status;
      r.element = element;
      r.last    = last;
      awaited_replies.push_back(r);
   endfunction

   // shadow list update plus expected responses for one accepted request
   function automatic void apply_list_request(logic [1:0] kind, olist_pkg::data_type value,
                                              logic [7:0] pos);
      int hit;
      hit = -1;
      case (kind)
         olist_pkg::KIND_APPEND: begin
            if (shadow_list.size() >= CAPACITY) begin
               expect_reply(olist_pkg::STATUS_FULL, '0, 1'b1);
            end else begin
               shadow_list.push_back(value);
               expect_reply(olist_pkg::STATUS_OK, '0, 1'b1);
            end
         end
         olist_pkg::KIND_INSERT: begin
            if (pos == 0 || int'(pos) > shadow_list.size() + 1) begin
               expect_reply(olist_pkg::STATUS_RANGE, '0, 1'b1);
            end else if (shadow_list.size() >= CAPACITY) begin
               expect_reply(olist_pkg::STATUS_FULL, '0, 1'b1);
            end else begin
               shadow_list.insert(int'(pos) - 1, value);
               expect_reply(olist_pkg::STATUS_OK, '0, 1'b1);
            end
         end
         olist_pkg::KIND_DELETE: begin
            if (shadow_list.size() == 0) begin
               expect_reply(olist_pkg::STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < shadow_list.size(); i++) begin
                  if (hit < 0 && shadow_list[i] == value) hit = i;
               end
               if (hit < 0) begin
                  expect_reply(olist_pkg::STATUS_NOTFOUND, '0, 1'b1);
               end else begin
                  shadow_list.delete(hit);
                  expect_reply(olist_pkg::STATUS_OK, '0, 1'b1);
               end
            end
         end
         default: begin
            if (shadow_list.size() == 0) begin
               expect_reply(olist_pkg::STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < shadow_list.size(); i++)
                  expect_reply(olist_pkg::STATUS_OK, shadow_list[i],
                               i == shadow_list.size() - 1);
            end
         end
      endcase
      if (shadow_list.size() == CAPACITY) full_count++;
   endfunction

   task automatic send_request(logic [1:0] kind, olist_pkg::data_type value,
                               logic [7:0] pos);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_value    <= value;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
      apply_list_request(kind, value, pos);
      sent_count++;
   endtask

   function automatic olist_pkg::data_type pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         // small values make duplicates likely
         2, 3: return olist_pkg::data_type'($urandom_range(0, 7));
         default: return olist_pkg::data_type'($urandom);
      endcase
   endfunction

   task automatic run_random_requests(int n);
      logic [1:0]          kind;
      olist_pkg::data_type value;
      logic [7:0]          pos;
      int         roll;
      int         add_limit;
      for (int i = 0; i < n; i++) begin
         // alternate between growing toward full and shrinking toward empty
         add_limit = ((i / 32) % 2 == 0) ? 65 : 35;
         roll = $urandom_range(0, 99);
         value = pick_value();
         pos = 8'($urandom_range(0, 255));
         if (roll < 10) begin
            kind = olist_pkg::KIND_DUMP;
         end else if (roll < add_limit) begin
            kind = ($urandom_range(0, 1) == 1) ? olist_pkg::KIND_INSERT
                                               : olist_pkg::KIND_APPEND;
            if (kind == olist_pkg::KIND_INSERT && $urandom_range(0, 3) != 0)
               pos = 8'($urandom_range(1, shadow_list.size() + 1));
         end else begin
            kind = olist_pkg::KIND_DELETE;
            if (shadow_list.size() > 0 && $urandom_range(0, 3) != 0)
               value = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
         end
         send_request(kind, value, pos);
      end
   endtask

   task automatic test_empty_list();
      send_request(olist_pkg::KIND_DUMP, 32'sd0, 8'd0);
      send_request(olist_pkg::KIND_DELETE, 32'sd5, 8'd0);
      send_request(olist_pkg::KIND_INSERT, 32'sd9, 8'd0);
      send_request(olist_pkg::KIND_INSERT, 32'sd9, 8'd2);
      send_request(olist_pkg::KIND_INSERT, 32'sh8000_0000, 8'd1);
   endtask

   task automatic test_positions_and_extremes();
      send_request(olist_pkg::KIND_APPEND, 32'sh7fff_ffff, 8'd0);
      send_request(olist_pkg::KIND_INSERT, -32'sd1, 8'd3);
      send_request(olist_pkg::KIND_INSERT, 32'sd1, 8'd255);
      send_request(olist_pkg::KIND_INSERT, 32'sd0, 8'd2);
      send_request(olist_pkg::KIND_DELETE, 32'sd12345, 8'd0);
      send_request(olist_pkg::KIND_DELETE, 32'sd0, 8'd0);
   endtask

   task automatic test_full_list();
      while (shadow_list.size() < CAPACITY)
         send_request(olist_pkg::KIND_APPEND, olist_pkg::data_type'($urandom),
                      8'($urandom));
      send_request(olist_pkg::KIND_APPEND, 32'sd3, 8'd0);
      send_request(olist_pkg::KIND_INSERT, 32'sd3, 8'd17);
      send_request(olist_pkg::KIND_INSERT, 32'sd3, 8'd18);
      send_request(olist_pkg::KIND_DUMP, 32'sd0, 8'd0);
      send_request(olist_pkg::KIND_DELETE, 32'sh8000_0000, 8'd0);
   endtask

   task automatic test_random_with_stalls();
      idling_on = 1'b1;
      run_random_requests(260);
   endtask

   task automatic test_random_back_to_back();
      idling_on = 1'b0;
      run_random_requests(40);
   endtask

   function automatic void check_reply();
      list_reply_type want;
      if (awaited_replies.size() == 0) begin
         $display("%0t: unexpected response status %0d element %0d last %0b",
                  $time, rsp_status, rsp_element, rsp_last);
         mismatch_count++;
         return;
      end
      want = awaited_replies.pop_front();
      checked_count++;
      if (rsp_status !== want.status) begin
         $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
         mismatch_count++;
      end
      if (rsp_element !== want.element) begin
         $display("%0t: element expected %0d actual %0d", $time, want.element, rsp_element);
         mismatch_count++;
      end
      if (rsp_last !== want.last) begin
         $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_last);
         mismatch_count++;
      end
   endfunction

   // response side: check accepted responses, stall in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_reply();
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                  $time, cycle_count, awaited_replies.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      idling_on = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_positions_and_extremes();
      test_full_list();
      test_random_with_stalls();
      test_random_back_to_back();
      req_valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d requests (append, insert, delete, dump), checked %0d responses",
               sent_count, checked_count);
      $display("list held at capacity after %0d requests", full_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/olist_pkg.sv
rtl/core/olist_cell.sv
rtl/core/ordered_list_engine_unit.sv
tb/sv/tb_ordered_list_engine_unit.sv
